[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Overlapping implication: the consequent holds in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Non-overlapping implication: the consequent holds in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/rcw_pkg.sv]
// Types, command codes and reset constants of the Reno congestion window unit.
package rcw_pkg;

    localparam int unsigned MSS_W  = 16;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned PROD_W = MSS_W + WORD_W;
    localparam int unsigned CNT_W  = 5;

    // Step counts of the serial multiply and divide, minus one.
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MSS_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

    // Event codes.
    localparam logic [2:0] CMD_ACK       = 3'd0;
    localparam logic [2:0] CMD_FAST_RETX = 3'd1;
    localparam logic [2:0] CMD_TIMEOUT   = 3'd2;
    localparam logic [2:0] CMD_INFLATE   = 3'd3;
    localparam logic [2:0] CMD_ESTABLISH = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MSS       = 2'd0;
    localparam logic [1:0] CFG_INIT_THR  = 2'd1;
    localparam logic [1:0] CFG_WIN_CEIL  = 2'd2;

    // Reset values.
    localparam logic [MSS_W-1:0]  RST_MSS       = 16'd1460;
    localparam logic [WORD_W-1:0] RST_INIT_THR  = 32'd65535;
    localparam logic [WORD_W-1:0] RST_WIN_CEIL  = 32'd1048576;
    localparam logic [WORD_W-1:0] RST_WINDOW    = 32'd1460;
    localparam logic [WORD_W-1:0] RST_THRESHOLD = 32'd65535;

    // Request to the serial multiply/divide unit.
    typedef struct packed {
        logic              start;
        logic              do_div;
        logic [WORD_W-1:0] multiplicand;
        logic [MSS_W-1:0]  multiplier;
        logic [WORD_W-1:0] divisor;
    } rcw_ctl_t;

    // Status returned by the unit; sat stays valid until the next start.
    typedef struct packed {
        logic done;
        logic sat;
    } rcw_stat_t;

endpackage

[rtl/core/reno_congestion_window_unit.sv]
// Top level of the TCP Reno congestion window and slow start threshold keeper.
//
// One event transaction in gives exactly one result transaction out. Events
// that need no multiply go from acceptance through S_APPLY to the result
// register. A fast retransmit first runs the 16-step bit-serial multiply of
// mss by the duplicate ack count. An ack in congestion avoidance runs 16
// multiply steps for mss*acked, one range check, 32 steps of the restoring
// divider by the current window, and the hand-over to the result register.
// When the quotient would not fit in 32 bits, including a zero window, the
// divider is skipped. No new event is taken while one is in progress. A new
// event is accepted on the cycle after the previous one has reached the
// result register, even while that result still waits to be taken; a result
// that waits holds the next event in S_APPLY until it is taken.
// Configuration writes take effect at once and must be made only while no
// event is in progress.
`include "assert_macros.svh"

module reno_congestion_window_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] acked_bytes,
    input  logic [31:0] inflight_bytes,
    input  logic [7:0]  dup_ack_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] window_bytes,
    output logic [31:0] threshold_bytes,
    output logic        in_slow_start
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CALC  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t       state_reg, state_next;

    logic [15:0]  mss_reg;
    logic [31:0]  init_thr_reg;
    logic [31:0]  win_ceil_reg;
    logic [31:0]  window_reg, window_next;
    logic [31:0]  threshold_reg, threshold_next;

    logic [2:0]   cmd_reg;
    logic [31:0]  acked_reg;
    logic [31:0]  loss_thr_reg;
    logic         avoid_reg;

    logic         out_valid_reg, out_valid_next;
    logic [31:0]  window_bytes_reg;
    logic [31:0]  threshold_bytes_reg;

    logic         accept;
    logic         avoid_now;
    logic [31:0]  loss_half;
    logic [31:0]  loss_floor;
    logic [31:0]  loss_thr;
    logic         load;

    logic [31:0]  op_a, op_b;
    logic         force_sat;
    logic         keep_win;
    logic [32:0]  sum;
    logic [31:0]  capped;
    logic [31:0]  quotient;

    rcw_pkg::rcw_ctl_t            ctl;
    rcw_pkg::rcw_stat_t           stat;
    logic [rcw_pkg::PROD_W-1:0]   unit_result;

    rcw_mul_div u_mul_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .stat   (stat),
        .result (unit_result)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign avoid_now  = (window_reg >= threshold_reg);

    assign loss_half  = {1'b0, inflight_bytes[31:1]};
    assign loss_floor = {15'b0, mss_reg, 1'b0};
    assign loss_thr   = (loss_half > loss_floor) ? loss_half : loss_floor;

    // Only avoidance acks and fast retransmits need the serial unit.
    assign ctl.start        = accept && (((cmd == rcw_pkg::CMD_ACK) && avoid_now)
                                         || (cmd == rcw_pkg::CMD_FAST_RETX));
    assign ctl.do_div       = (cmd == rcw_pkg::CMD_ACK);
    assign ctl.multiplicand = (cmd == rcw_pkg::CMD_ACK) ? acked_bytes
                                                        : {24'b0, dup_ack_count};
    assign ctl.multiplier   = mss_reg;
    assign ctl.divisor      = window_reg;

    assign quotient = unit_result[31:0];

    always_comb
    begin
        op_a           = window_reg;
        op_b           = '0;
        force_sat      = 1'b0;
        keep_win       = 1'b0;
        threshold_next = threshold_reg;
        unique case (cmd_reg)
            rcw_pkg::CMD_ACK:
            begin
                if (avoid_reg)
                begin
                    op_b      = (quotient == '0) ? 32'd1 : quotient;
                    force_sat = stat.sat;
                end
                else
                begin
                    op_b = acked_reg;
                end
            end
            rcw_pkg::CMD_FAST_RETX:
            begin
                threshold_next = loss_thr_reg;
                op_a           = loss_thr_reg;
                op_b           = {8'b0, unit_result[23:0]};
            end
            rcw_pkg::CMD_TIMEOUT:
            begin
                threshold_next = loss_thr_reg;
                op_a           = {16'b0, mss_reg};
            end
            rcw_pkg::CMD_INFLATE:
            begin
                op_b = {16'b0, mss_reg};
            end
            rcw_pkg::CMD_ESTABLISH:
            begin
                threshold_next = init_thr_reg;
                op_a           = {16'b0, mss_reg};
            end
            default:
            begin
                keep_win = 1'b1;
            end
        endcase
    end

    assign sum         = {1'b0, op_a} + {1'b0, op_b};
    assign capped      = (force_sat || (sum > {1'b0, win_ceil_reg})) ? win_ceil_reg
                                                                     : sum[31:0];
    assign window_next = keep_win ? window_reg : capped;

    // The result register is loaded once it is empty or being emptied.
    assign load = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ctl.start ? S_CALC : S_APPLY;
                end
            end
            S_CALC:
            begin
                if (stat.done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mss_reg       <= rcw_pkg::RST_MSS;
            init_thr_reg  <= rcw_pkg::RST_INIT_THR;
            win_ceil_reg  <= rcw_pkg::RST_WIN_CEIL;
            window_reg    <= rcw_pkg::RST_WINDOW;
            threshold_reg <= rcw_pkg::RST_THRESHOLD;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rcw_pkg::CFG_MSS:      mss_reg      <= cfg_data[15:0];
                    rcw_pkg::CFG_INIT_THR: init_thr_reg <= cfg_data;
                    rcw_pkg::CFG_WIN_CEIL: win_ceil_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (load)
            begin
                window_reg    <= window_next;
                threshold_reg <= threshold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd;
            acked_reg    <= acked_bytes;
            loss_thr_reg <= loss_thr;
            avoid_reg    <= avoid_now;
        end
        if (load)
        begin
            window_bytes_reg    <= window_next;
            threshold_bytes_reg <= threshold_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign window_bytes    = window_bytes_reg;
    assign threshold_bytes = threshold_bytes_reg;
    assign in_slow_start   = (window_bytes_reg < threshold_bytes_reg);

    `ASSERT_IMPLY(a_start_from_idle, ctl.start, state_reg == S_IDLE, "unit started outside idle")
    `ASSERT_IMPLY(a_done_in_calc, stat.done, state_reg == S_CALC, "unit finished while not awaited")
    `ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "second transaction taken during an event")
    `ASSERT_NEXT(a_result_matches_state, load, (window_bytes == window_reg) && (threshold_bytes == threshold_reg), "result differs from stored state")

endmodule

[rtl/core/rcw_mul_div.sv]
// Bit-serial multiplier followed by an optional bit-serial restoring divider.
module rcw_mul_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rcw_pkg::rcw_ctl_t            ctl,
    output rcw_pkg::rcw_stat_t           stat,
    output logic [rcw_pkg::PROD_W-1:0]   result
);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_CHK  = 4'b0100,
        U_DIV  = 4'b1000
    } ustate_t;

    ustate_t                        state_reg, state_next;
    logic [rcw_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           do_div_reg, do_div_next;
    logic                           done_reg, done_next;
    logic                           sat_reg, sat_next;
    logic [rcw_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [rcw_pkg::WORD_W-1:0]     mcand_reg, mcand_next;
    logic [rcw_pkg::WORD_W-1:0]     div_reg, div_next;
    logic [rcw_pkg::WORD_W-1:0]     rem_reg, rem_next;

    logic [rcw_pkg::WORD_W:0]       mul_sum;
    logic [rcw_pkg::WORD_W:0]       trial;
    logic [rcw_pkg::WORD_W:0]       trial_diff;
    logic                           trial_ge;
    logic                           hi_ge;

    // Product low bits hold the multiplier as it shifts out; during division
    // the low word holds the dividend bits shifting out and quotient bits in.
    assign mul_sum    = {1'b0, prod_reg[rcw_pkg::PROD_W-1:rcw_pkg::MSS_W]}
                      + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    assign trial      = {rem_reg, prod_reg[rcw_pkg::WORD_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    // A quotient of 2^32 or more is flagged instead of computed.
    assign hi_ge      = ({16'b0, prod_reg[rcw_pkg::PROD_W-1:rcw_pkg::WORD_W]} >= div_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        do_div_next = do_div_reg;
        done_next   = 1'b0;
        sat_next    = sat_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    prod_next   = {{rcw_pkg::WORD_W{1'b0}}, ctl.multiplier};
                    mcand_next  = ctl.multiplicand;
                    div_next    = ctl.divisor;
                    do_div_next = ctl.do_div;
                    sat_next    = 1'b0;
                    cnt_next    = rcw_pkg::MUL_LAST;
                    state_next  = U_MUL;
                end
            end
            U_MUL:
            begin
                prod_next = {mul_sum, prod_reg[rcw_pkg::MSS_W-1:1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (do_div_reg)
                    begin
                        state_next = U_CHK;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = U_IDLE;
                    end
                end
            end
            U_CHK:
            begin
                if (hi_ge)
                begin
                    sat_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
                else
                begin
                    rem_next   = {16'b0, prod_reg[rcw_pkg::PROD_W-1:rcw_pkg::WORD_W]};
                    cnt_next   = rcw_pkg::DIV_LAST;
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                rem_next  = trial_ge ? trial_diff[rcw_pkg::WORD_W-1:0]
                                     : trial[rcw_pkg::WORD_W-1:0];
                prod_next = {prod_reg[rcw_pkg::PROD_W-1:rcw_pkg::WORD_W],
                             prod_reg[rcw_pkg::WORD_W-2:0], trial_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            cnt_reg    <= '0;
            do_div_reg <= 1'b0;
            done_reg   <= 1'b0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            do_div_reg <= do_div_next;
            done_reg   <= done_next;
            sat_reg    <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign result    = prod_reg;

endmodule
